// ----- design/bresenham_line_rasterizer_defines.svh -----
// Assertion macros for the Bresenham line rasterizer.
// Every macro samples on clk_i and is disabled while rst_ni is low.
`ifndef BRESENHAM_LINE_RASTERIZER_DEFINES_SVH
`define BRESENHAM_LINE_RASTERIZER_DEFINES_SVH

// Condition that must hold at every clock edge.
`define BLR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication that is checked in the same cycle.
`define BLR_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the next cycle.
`define BLR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/blr_pkg.sv -----
// Shared types, constants and the coordinate clip function of the line rasterizer.
// Used by the front end, the walker, the top level and the checker.
`timescale 1ns / 1ps
package blr_pkg;

  localparam int COORD_W   = 6;
  localparam int DELTA_W   = 6;
  localparam int ERR_W     = 9;
  localparam int GRID_SIZE = 64;

  // Queue depths between the front end and the walker, and at the output.
  localparam int JOB_DEPTH = 2;
  localparam int PIX_DEPTH = 2;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [DELTA_W-1:0] delta_t;
  typedef logic signed [ERR_W-1:0] err_t;

  // One classified line, ready to be walked.
  typedef struct packed {
    logic   walk_is_vertical;
    logic   minor_step_negative;
    coord_t major_pos;
    coord_t minor_pos;
    coord_t major_end;
    delta_t major_delta;
    delta_t minor_delta;
    err_t   error_term;
  } blr_job_t;

  typedef struct packed {
    coord_t pixel_x;
    coord_t pixel_y;
    logic   last_pixel;
  } blr_pixel_t;

  // Coordinates at or beyond the grid edge saturate to the last cell.
  function automatic coord_t clip_coord(input coord_t c);
    if (int'(c) >= GRID_SIZE) begin
      return COORD_W'(GRID_SIZE - 1);
    end
    return c;
  endfunction

endpackage

// ----- design/bresenham_line_rasterizer.sv -----
// Bresenham line rasterizer: accepts a line as two grid endpoints per transfer and
// returns one transfer per plotted pixel, walking upward along the major axis and
// marking the final pixel. The far endpoint is not drawn and a line with identical
// endpoints returns nothing. A line whose major span is n cells gives n pixels at one
// pixel per cycle while the pixel queue has room; the walker first loads the line,
// then plots its pixels, and that single walker sets the sustained rate. The front
// end classifies a line in the cycle it is accepted and stores it in a short job
// queue, so new lines are taken while an earlier one is still being walked, until
// the queue fills. Pixels wait in a small output queue; stalling pop stalls the walk.
// Depends on blr_pkg, blr_front, blr_fifo and blr_walker.
`timescale 1ns / 1ps
module bresenham_line_rasterizer #(
  parameter int JobDepth = blr_pkg::JOB_DEPTH,
  parameter int PixDepth = blr_pkg::PIX_DEPTH
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push,
  output logic            full,
  input  blr_pkg::coord_t start_x_i,
  input  blr_pkg::coord_t start_y_i,
  input  blr_pkg::coord_t end_x_i,
  input  blr_pkg::coord_t end_y_i,
  input  logic            pop,
  output logic            empty,
  output blr_pkg::coord_t pixel_x_o,
  output blr_pkg::coord_t pixel_y_o,
  output logic            last_pixel_o
);
  import blr_pkg::*;

  blr_job_t   front_job, walk_job;
  blr_pixel_t walk_pix, out_pix;
  logic       job_wr, job_full, job_rd, job_empty;
  logic       pix_wr, pix_full;

  blr_front u_front (
    .push_i     (push),
    .full_o     (full),
    .start_x_i  (start_x_i),
    .start_y_i  (start_y_i),
    .end_x_i    (end_x_i),
    .end_y_i    (end_y_i),
    .job_full_i (job_full),
    .job_wr_o   (job_wr),
    .job_o      (front_job)
  );

  blr_fifo #(
    .T     (blr_job_t),
    .DEPTH (JobDepth)
  ) u_job_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (job_wr),
    .wr_data_i (front_job),
    .full_o    (job_full),
    .rd_i      (job_rd),
    .rd_data_o (walk_job),
    .empty_o   (job_empty)
  );

  blr_walker u_walker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_empty_i (job_empty),
    .job_i       (walk_job),
    .job_rd_o    (job_rd),
    .pix_full_i  (pix_full),
    .pix_wr_o    (pix_wr),
    .pix_o       (walk_pix)
  );

  blr_fifo #(
    .T     (blr_pixel_t),
    .DEPTH (PixDepth)
  ) u_pix_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (pix_wr),
    .wr_data_i (walk_pix),
    .full_o    (pix_full),
    .rd_i      (pop),
    .rd_data_o (out_pix),
    .empty_o   (empty)
  );

  assign pixel_x_o    = out_pix.pixel_x;
  assign pixel_y_o    = out_pix.pixel_y;
  assign last_pixel_o = out_pix.last_pixel;

endmodule

// ----- design/blr_fifo.sv -----
// Small first-in first-out queue with a count, used for line jobs and for pixels.
// Depends on nothing but its type and depth parameters.
`timescale 1ns / 1ps
module blr_fifo #(
  parameter type T     = logic,
  parameter int  DEPTH = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_i,
  input  T     wr_data_i,
  output logic full_o,
  input  logic rd_i,
  output T     rd_data_o,
  output logic empty_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  T               mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_wr, do_rd;

  assign full_o    = (count_q == CntW'(DEPTH));
  assign empty_o   = (count_q == '0);
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_d = count_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

// ----- design/blr_front.sv -----
// Front end: clips the endpoints, picks the major axis, orders the endpoints
// and sets up deltas and the initial error term. Depends on blr_pkg.
`timescale 1ns / 1ps
module blr_front (
  input  logic              push_i,
  output logic              full_o,
  input  blr_pkg::coord_t   start_x_i,
  input  blr_pkg::coord_t   start_y_i,
  input  blr_pkg::coord_t   end_x_i,
  input  blr_pkg::coord_t   end_y_i,
  input  logic              job_full_i,
  output logic              job_wr_o,
  output blr_pkg::blr_job_t job_o
);
  import blr_pkg::*;

  coord_t x0, y0, x1, y1;
  coord_t adx, ady;
  coord_t maj0, maj1, min0, min1;
  coord_t lo_maj, hi_maj, lo_min, hi_min;
  logic   vertical, swap, minor_neg;
  delta_t dmaj, dmin;

  always_comb begin
    x0 = clip_coord(start_x_i);
    y0 = clip_coord(start_y_i);
    x1 = clip_coord(end_x_i);
    y1 = clip_coord(end_y_i);
    adx = (x1 > x0) ? x1 - x0 : x0 - x1;
    ady = (y1 > y0) ? y1 - y0 : y0 - y1;

    // Ties go to the y-major walk.
    vertical = !(adx > ady);
    maj0 = vertical ? y0 : x0;
    maj1 = vertical ? y1 : x1;
    min0 = vertical ? x0 : y0;
    min1 = vertical ? x1 : y1;

    // Only the major axis decides the swap; the minor direction follows.
    swap   = (maj0 > maj1);
    lo_maj = swap ? maj1 : maj0;
    hi_maj = swap ? maj0 : maj1;
    lo_min = swap ? min1 : min0;
    hi_min = swap ? min0 : min1;

    minor_neg = (hi_min < lo_min);
    dmin      = minor_neg ? DELTA_W'(lo_min - hi_min) : DELTA_W'(hi_min - lo_min);
    dmaj      = DELTA_W'(hi_maj - lo_maj);

    job_o.walk_is_vertical    = vertical;
    job_o.minor_step_negative = minor_neg;
    job_o.major_pos           = lo_maj;
    job_o.minor_pos           = lo_min;
    job_o.major_end           = hi_maj;
    job_o.major_delta         = dmaj;
    job_o.minor_delta         = dmin;
    job_o.error_term          = $signed({2'b00, dmin, 1'b0}) - $signed({3'b000, dmaj});
  end

  assign full_o = job_full_i;
  // A line with identical endpoints plots nothing and never reaches the walker.
  assign job_wr_o = push_i && !job_full_i && (dmaj != '0);

endmodule

// ----- design/blr_walker.sv -----
// Back end: walks one line job at a time, one pixel per cycle into the pixel queue
// while it has room. Depends on blr_pkg.
`timescale 1ns / 1ps
module blr_walker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                job_empty_i,
  input  blr_pkg::blr_job_t   job_i,
  output logic                job_rd_o,
  input  logic                pix_full_i,
  output logic                pix_wr_o,
  output blr_pkg::blr_pixel_t pix_o
);
  import blr_pkg::*;

  logic     busy_q, busy_d;
  blr_job_t job_q, job_d;
  logic     last;
  err_t     twice_min, twice_maj;

  assign twice_min = $signed({2'b00, job_q.minor_delta, 1'b0});
  assign twice_maj = $signed({2'b00, job_q.major_delta, 1'b0});
  assign last      = ({1'b0, job_q.major_pos} + 1'b1) == {1'b0, job_q.major_end};

  always_comb begin
    busy_d   = busy_q;
    job_d    = job_q;
    job_rd_o = 1'b0;
    pix_wr_o = 1'b0;

    pix_o.pixel_x    = job_q.walk_is_vertical ? job_q.minor_pos : job_q.major_pos;
    pix_o.pixel_y    = job_q.walk_is_vertical ? job_q.major_pos : job_q.minor_pos;
    pix_o.last_pixel = last;

    if (!busy_q) begin
      if (!job_empty_i) begin
        job_rd_o = 1'b1;
        job_d    = job_i;
        busy_d   = 1'b1;
      end
    end else if (!pix_full_i) begin
      pix_wr_o = 1'b1;
      if (job_q.error_term >= 0) begin
        job_d.minor_pos  = job_q.minor_step_negative ? job_q.minor_pos - 1'b1
                                                     : job_q.minor_pos + 1'b1;
        job_d.error_term = job_q.error_term + twice_min - twice_maj;
      end else begin
        job_d.error_term = job_q.error_term + twice_min;
      end
      job_d.major_pos = job_q.major_pos + 1'b1;
      if (last) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
  end

endmodule

// ----- design/blr_checker.sv -----
// Port-level checker for the line rasterizer, bound to the top level.
// Depends on blr_pkg and bresenham_line_rasterizer_defines.svh.
`timescale 1ns / 1ps
`include "bresenham_line_rasterizer_defines.svh"
module blr_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            pop,
  input logic            empty,
  input blr_pkg::coord_t pixel_x_o,
  input blr_pkg::coord_t pixel_y_o,
  input logic            last_pixel_o
);
  import blr_pkg::*;

  coord_t prev_x_q, prev_y_q;
  logic   prev_open_q;
  coord_t step_x, step_y;
  logic   adjacent;
  logic   out_xfer;

  assign out_xfer = pop && !empty;
  assign step_x   = (pixel_x_o > prev_x_q) ? pixel_x_o - prev_x_q : prev_x_q - pixel_x_o;
  assign step_y   = (pixel_y_o > prev_y_q) ? pixel_y_o - prev_y_q : prev_y_q - pixel_y_o;
  // Successive pixels of one line are distinct neighbors on the grid.
  assign adjacent = (step_x <= COORD_W'(1)) && (step_y <= COORD_W'(1))
                    && ((step_x != '0) || (step_y != '0));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_open_q <= 1'b0;
    end else if (out_xfer) begin
      prev_open_q <= !last_pixel_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_xfer) begin
      prev_x_q <= pixel_x_o;
      prev_y_q <= pixel_y_o;
    end
  end

  `BLR_ASSERT_NEXT(a_pixel_held, !empty && !pop, !empty && $stable(pixel_x_o) && $stable(pixel_y_o) && $stable(last_pixel_o), "pixel changed while waiting")
  `BLR_ASSERT_IMPL(a_pixel_in_grid, !empty, (int'(pixel_x_o) < GRID_SIZE) && (int'(pixel_y_o) < GRID_SIZE), "pixel outside the grid")
  `BLR_ASSERT_IMPL(a_pixel_adjacent, out_xfer && prev_open_q, adjacent, "pixel not adjacent to the one before")

endmodule

bind bresenham_line_rasterizer blr_checker u_blr_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .pop          (pop),
  .empty        (empty),
  .pixel_x_o    (pixel_x_o),
  .pixel_y_o    (pixel_y_o),
  .last_pixel_o (last_pixel_o)
);

// ----- sim/blr_line_checker.sv -----
// Checker for the line rasterizer: watches both queue-style channels, predicts the
// pixels of every accepted line and compares each pixel transfer in order.
// Depends on blr_pkg for the coordinate and pixel types.
`timescale 1ns / 1ps
module blr_line_checker (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  logic            full_i,
  input  blr_pkg::coord_t start_x_i,
  input  blr_pkg::coord_t start_y_i,
  input  blr_pkg::coord_t end_x_i,
  input  blr_pkg::coord_t end_y_i,
  input  logic            pop_i,
  input  logic            empty_i,
  input  blr_pkg::coord_t pixel_x_i,
  input  blr_pkg::coord_t pixel_y_i,
  input  logic            last_pixel_i,
  output int              fail_count_o,
  output int              pending_o
);
  import blr_pkg::*;

  blr_pixel_t expected_pixels [$];
  blr_pixel_t want;
  int         mismatches    = 0;
  int         pending_count = 0;

  assign fail_count_o = mismatches;
  assign pending_o    = pending_count;

  function automatic coord_t saturate_coord(input coord_t c);
    return (int'(c) > GRID_SIZE - 1) ? coord_t'(GRID_SIZE - 1) : c;
  endfunction

  // Walks the line upward along its major axis and queues one pixel per major step.
  task automatic rasterize_line(input coord_t sx, input coord_t sy,
                                input coord_t ex, input coord_t ey);
    coord_t     x0, y0, x1, y1;
    coord_t     maj0, maj1, min0, min1, swap, minor_pos;
    int         adx, ady, span, dmin, err, p;
    logic       vertical, step_neg;
    blr_pixel_t pix;
    x0  = saturate_coord(sx);
    y0  = saturate_coord(sy);
    x1  = saturate_coord(ex);
    y1  = saturate_coord(ey);
    adx = (x1 > x0) ? int'(x1) - int'(x0) : int'(x0) - int'(x1);
    ady = (y1 > y0) ? int'(y1) - int'(y0) : int'(y0) - int'(y1);
    // A tie in span goes to the vertical walk.
    vertical = !(adx > ady);
    if (vertical) begin
      maj0 = y0; maj1 = y1; min0 = x0; min1 = x1;
    end else begin
      maj0 = x0; maj1 = x1; min0 = y0; min1 = y1;
    end
    // Only the major axis decides the swap; the minor direction follows afterwards.
    if (maj0 > maj1) begin
      swap = maj0; maj0 = maj1; maj1 = swap;
      swap = min0; min0 = min1; min1 = swap;
    end
    dmin     = int'(min1) - int'(min0);
    step_neg = (dmin < 0);
    if (step_neg) begin
      dmin = -dmin;
    end
    span      = int'(maj1) - int'(maj0);
    err       = 2 * dmin - span;
    minor_pos = min0;
    for (p = int'(maj0); p < int'(maj1); p++) begin
      pix.pixel_x    = vertical ? minor_pos : coord_t'(p);
      pix.pixel_y    = vertical ? coord_t'(p) : minor_pos;
      pix.last_pixel = (p + 1 >= int'(maj1));
      expected_pixels.push_back(pix);
      if (err >= 0) begin
        minor_pos = step_neg ? minor_pos - 1'b1 : minor_pos + 1'b1;
        err += 2 * dmin - 2 * span;
      end else begin
        err += 2 * dmin;
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop_i && !empty_i) begin
        if (expected_pixels.size() == 0) begin
          $display("%0t: unexpected pixel transfer x=%0d y=%0d last=%0b", $time,
                   pixel_x_i, pixel_y_i, last_pixel_i);
          mismatches++;
        end else begin
          want = expected_pixels.pop_front();
          if (want.pixel_x != pixel_x_i || want.pixel_y != pixel_y_i ||
              want.last_pixel != last_pixel_i) begin
            $display("%0t: pixel mismatch, expected x=%0d y=%0d last=%0b, got x=%0d y=%0d last=%0b",
                     $time, want.pixel_x, want.pixel_y, want.last_pixel,
                     pixel_x_i, pixel_y_i, last_pixel_i);
            mismatches++;
          end
        end
      end
      if (push_i && !full_i) begin
        rasterize_line(start_x_i, start_y_i, end_x_i, end_y_i);
      end
      pending_count <= expected_pixels.size();
    end
  end

endmodule

// ----- sim/tb_top.sv -----
// Top of the line rasterizer regression: clock, reset, line stimulus, pixel
// draining with random stalls, a watchdog and the verdict.
// Depends on blr_pkg, bresenham_line_rasterizer and blr_line_checker.
`timescale 1ns / 1ps
module tb_top;
  import blr_pkg::*;

  localparam int RANDOM_LINES   = 160;
  localparam int RX_HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES   = 150;
  localparam int WATCHDOG_LIMIT = 3000;

  logic   clk_i;
  logic   rst_ni      = 1'b0;
  logic   push        = 1'b0;
  logic   pop         = 1'b0;
  logic   rx_hold_req = 1'b0;
  coord_t start_x     = '0;
  coord_t start_y     = '0;
  coord_t end_x       = '0;
  coord_t end_y       = '0;
  logic   full, empty, last_pixel;
  coord_t pixel_x, pixel_y;
  int     fail_count, pending;
  int     quiet_cycles = 0;
  coord_t sx, sy, ex, ey;
  bit     tx_steady = 1'b0;

  bresenham_line_rasterizer i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .start_x_i   (start_x),
    .start_y_i   (start_y),
    .end_x_i     (end_x),
    .end_y_i     (end_y),
    .pop         (pop),
    .empty       (empty),
    .pixel_x_o   (pixel_x),
    .pixel_y_o   (pixel_y),
    .last_pixel_o(last_pixel)
  );

  blr_line_checker i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_i      (full),
    .start_x_i   (start_x),
    .start_y_i   (start_y),
    .end_x_i     (end_x),
    .end_y_i     (end_y),
    .pop_i       (pop),
    .empty_i     (empty),
    .pixel_x_i   (pixel_x),
    .pixel_y_i   (pixel_y),
    .last_pixel_i(last_pixel),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len(input bit steady);
    int r;
    if (steady) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 45) begin
      return 0;
    end
    if (r < 85) begin
      return $urandom_range(1, 3);
    end
    if (r < 96) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  function automatic coord_t clamp_grid(input int v);
    if (v < 0) begin
      return '0;
    end
    if (v > 63) begin
      return coord_t'(63);
    end
    return coord_t'(v);
  endfunction

  task automatic pick_line(output coord_t x0, output coord_t y0,
                           output coord_t x1, output coord_t y1);
    int kind, dx, dy;
    kind = $urandom_range(0, 99);
    x0   = coord_t'($urandom_range(0, 63));
    y0   = coord_t'($urandom_range(0, 63));
    x1   = coord_t'($urandom_range(0, 63));
    y1   = coord_t'($urandom_range(0, 63));
    dx   = int'($urandom_range(0, 16)) - 8;
    dy   = int'($urandom_range(0, 16)) - 8;
    if (kind < 30) begin
      return;
    end else if (kind < 58) begin
      x1 = clamp_grid(int'(x0) + dx);
      y1 = clamp_grid(int'(y0) + dy);
    end else if (kind < 68) begin
      if (kind[0]) begin
        y1 = y0;
      end else begin
        x1 = x0;
      end
    end else if (kind < 86) begin
      // Diagonal and near-diagonal lines sit on the tie between the two walks.
      dx = int'($urandom_range(1, 30));
      dy = dx + ((kind < 78) ? 0 : int'($urandom_range(0, 2)) - 1);
      x1 = clamp_grid(int'(x0) + ($urandom_range(0, 1) ? dx : -dx));
      y1 = clamp_grid(int'(y0) + ($urandom_range(0, 1) ? dy : -dy));
    end else if (kind < 92) begin
      x1 = x0;
      y1 = y0;
    end else begin
      x0 = $urandom_range(0, 1) ? coord_t'(63) : '0;
      y0 = $urandom_range(0, 1) ? coord_t'(63) : '0;
      x1 = $urandom_range(0, 1) ? coord_t'(63) : '0;
      y1 = $urandom_range(0, 1) ? coord_t'(63) : '0;
    end
  endtask

  // Push stays high after a transfer unless the next line comes after a gap.
  task automatic send_line(input int x0, input int y0,
                           input int x1, input int y1, input int gap);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push    <= 1'b1;
    start_x <= coord_t'(x0);
    start_y <= coord_t'(y0);
    end_x   <= coord_t'(x1);
    end_y   <= coord_t'(y1);
    @(posedge clk_i);
    while (full) @(posedge clk_i);
  endtask

  task automatic wait_all_pixels();
    push <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Corner to corner, both diagonals and both directions.
    send_line(0, 0, 63, 63, gap_len(tx_steady));
    send_line(63, 63, 0, 0, gap_len(tx_steady));
    send_line(0, 63, 63, 0, gap_len(tx_steady));
    send_line(63, 0, 0, 63, gap_len(tx_steady));
    // Full-length axis-aligned lines.
    send_line(0, 0, 63, 0, gap_len(tx_steady));
    send_line(63, 5, 0, 5, gap_len(tx_steady));
    send_line(7, 0, 7, 63, gap_len(tx_steady));
    send_line(7, 63, 7, 0, gap_len(tx_steady));
    // Identical endpoints give no pixels.
    send_line(0, 0, 0, 0, gap_len(tx_steady));
    send_line(63, 63, 63, 63, gap_len(tx_steady));
    send_line(21, 42, 21, 42, gap_len(tx_steady));
    // Single-cell lines on each axis.
    send_line(10, 10, 11, 10, gap_len(tx_steady));
    send_line(10, 10, 10, 11, gap_len(tx_steady));
    // Swapped endpoints where the minor axis then steps downward, and not swapped.
    send_line(40, 10, 5, 30, gap_len(tx_steady));
    send_line(5, 30, 40, 10, gap_len(tx_steady));
    send_line(10, 40, 30, 5, gap_len(tx_steady));
    send_line(30, 5, 10, 40, gap_len(tx_steady));
    // Shallow, steep and nearly tied slopes.
    send_line(0, 0, 63, 1, gap_len(tx_steady));
    send_line(0, 1, 63, 0, gap_len(tx_steady));
    send_line(0, 0, 1, 63, gap_len(tx_steady));
    send_line(0, 0, 63, 62, gap_len(tx_steady));
    send_line(0, 0, 62, 63, gap_len(tx_steady));
    send_line(42, 21, 21, 42, gap_len(tx_steady));
    wait_all_pixels();

    for (int n = 0; n < RANDOM_LINES; n++) begin
      if (n % 25 == 0) begin
        tx_steady = ($urandom_range(0, 3) == 0);
      end
      // Let the pixel side stall for a long time while lines keep coming.
      if (n == 60) begin
        rx_hold_req <= 1'b1;
      end
      if (n == 120) begin
        wait_all_pixels();
      end
      pick_line(sx, sy, ex, ey);
      send_line(int'(sx), int'(sy), int'(ex), int'(ey), gap_len(tx_steady));
    end

    wait_all_pixels();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("bresenham_line_rasterizer regression: pass");
    end else begin
      $display("bresenham_line_rasterizer regression: fail");
    end
    $finish;
  end

  initial begin : pixel_sink
    int gap;
    int tries;
    bit steady;
    bit held;
    tries  = 0;
    steady = 1'b0;
    held   = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (tries % 100 == 0) begin
        steady = ($urandom_range(0, 3) == 0);
      end
      tries++;
      if (rx_hold_req && !held) begin
        held = 1'b1;
        pop <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk_i);
      end
      gap = gap_len(steady);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      pop <= 1'b1;
      @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("bresenham_line_rasterizer regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

// ----- filelist.f -----
+incdir+design
design/blr_pkg.sv
design/blr_fifo.sv
design/blr_front.sv
design/blr_walker.sv
design/bresenham_line_rasterizer.sv
design/blr_checker.sv
sim/blr_line_checker.sv
sim/tb_top.sv
